FILE: rtl/datagram_stream_deframer_core_macros.svh
// Assertion helpers for the deframer checker
`ifndef DATAGRAM_STREAM_DEFRAMER_CORE_MACROS_SVH
`define DATAGRAM_STREAM_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define DSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: rtl/dsd_pkg.sv
package dsd_pkg;

    localparam logic [11:0] MAGIC_VALUE = 12'd3982;
    localparam logic [3:0]  TYPE_AUDIO  = 4'd1;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_AUDIO   = 3'd1;
    localparam logic [2:0] KIND_BAD     = 3'd2;
    localparam logic [2:0] KIND_LONG    = 3'd3;
    localparam logic [2:0] KIND_OTHER   = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } dsd_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_type;
        logic [15:0] frame_length;
        logic        last;
    } dsd_result_t;

endpackage

FILE: rtl/dsd_byte_if.sv
interface dsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: rtl/dsd_result_if.sv
interface dsd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_type;
    logic [15:0] frame_length;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output frame_type,
                    output frame_length, output last, input ready);
    modport sink (input valid, input kind, input payload_byte, input frame_type,
                  input frame_length, input last, output ready);
endinterface

FILE: rtl/dsd_cfg_if.sv
interface dsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink (input valid, input max_payload, output ready);
endinterface

FILE: rtl/dsd_in_stage.sv
module dsd_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    dsd_byte_if.sink         stream,
    input  logic             advance,
    output dsd_pkg::dsd_beat_t beat
);
    import dsd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    assign stream.ready = !valid_reg || advance;
    assign load         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= stream.stream_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;
endmodule

FILE: rtl/dsd_parser.sv
module dsd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           data,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    output logic                 emit,
    output dsd_pkg::dsd_result_t res
);
    import dsd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PASS,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [23:0] hdr_reg;
    logic [23:0] hdr_next;
    logic [15:0] left_reg;
    logic [15:0] left_next;
    logic [15:0] max_reg;
    logic [15:0] left_dec;
    logic [11:0] magic;
    logic [3:0]  ftype;
    logic [15:0] flen;

    assign left_dec = left_reg - 16'd1;
    assign magic    = {data, hdr_reg[23:20]};
    assign ftype    = hdr_reg[19:16];
    assign flen     = hdr_reg[15:0];

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        left_next  = left_reg;
        emit       = 1'b0;
        res        = '0;
        if (fire)
        begin
            case (phase_reg)
                PH_PASS:
                begin
                    left_next        = left_dec;
                    emit             = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = data;
                    res.frame_type   = TYPE_AUDIO;
                    res.frame_length = flen;
                    res.last         = (left_dec == 16'd0);
                    if (left_dec == 16'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    if (cnt_reg != 2'd3)
                    begin
                        case (cnt_reg)
                            2'd0:    hdr_next[7:0]   = data;
                            2'd1:    hdr_next[15:8]  = data;
                            default: hdr_next[23:16] = data;
                        endcase
                        cnt_next = cnt_reg + 2'd1;
                    end
                    else
                    begin
                        cnt_next         = 2'd0;
                        emit             = 1'b1;
                        res.frame_type   = ftype;
                        res.frame_length = flen;
                        if (magic != MAGIC_VALUE)
                        begin
                            res.kind = KIND_BAD;
                        end
                        else
                        begin
                            left_next = flen;
                            if (flen > max_reg || ftype != TYPE_AUDIO)
                            begin
                                res.kind   = (flen > max_reg) ? KIND_LONG : KIND_OTHER;
                                phase_next = (flen != 16'd0) ? PH_SKIP : PH_HEADER;
                            end
                            else
                            begin
                                res.kind   = KIND_AUDIO;
                                res.last   = (flen == 16'd0);
                                phase_next = (flen != 16'd0) ? PH_PASS : PH_HEADER;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= 2'd0;
            hdr_reg   <= 24'd0;
            left_reg  <= 16'd0;
            max_reg   <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hdr_reg   <= hdr_next;
            left_reg  <= left_next;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
        end
    end
endmodule

FILE: rtl/dsd_out_stage.sv
module dsd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dsd_pkg::dsd_result_t res,
    output logic                free,
    dsd_result_if.source        result
);
    import dsd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    dsd_result_t data_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.kind         = data_reg.kind;
    assign result.payload_byte = data_reg.payload_byte;
    assign result.frame_type   = data_reg.frame_type;
    assign result.frame_length = data_reg.frame_length;
    assign result.last         = data_reg.last;
endmodule

FILE: rtl/datagram_stream_deframer_core.sv
// Datagram stream deframer.
// stream: one byte of the datagram stream per beat. Each datagram opens
//   with a 4-byte little-endian header (magic, type, payload length).
// result: one status beat after the fourth header byte (audio ok, bad magic,
//   too long, other type), then one beat per payload byte of an audio frame,
//   last set on the final beat (on the status beat for an empty frame).
//   Skipped payload bytes produce no beat.
// cfg: write max_payload at any beat while the block is idle; ready is
//   always high.
// Throughput: one byte per cycle unless result.ready stalls, set by the
//   single pass from the input register through the parser into the
//   result register, which loads a byte's result once it is free.
// Reset: max_payload returns to 65535 and header collection restarts.
// Stall: when result.ready is low, the result register holds, the input
//   register fills, and stream.ready drops as soon as the input register
//   holds a byte.
module datagram_stream_deframer_core (
    input  logic          clk,
    input  logic          rst_n,
    dsd_byte_if.sink      stream,
    dsd_cfg_if.sink       cfg,
    dsd_result_if.source  result
);
    import dsd_pkg::*;

    dsd_beat_t   beat;
    dsd_result_t res;
    logic        emit;
    logic        free;
    logic        advance;

    assign advance   = beat.valid && free;
    assign cfg.ready = 1'b1;

    dsd_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .advance (advance),
        .beat    (beat)
    );

    dsd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .data     (beat.data),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.max_payload),
        .emit     (emit),
        .res      (res)
    );

    dsd_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (emit),
        .res    (res),
        .free   (free),
        .result (result)
    );
endmodule

FILE: rtl/dsd_checker.sv
`include "datagram_stream_deframer_core_macros.svh"

module dsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  kind,
    input logic [7:0]  payload_byte,
    input logic [3:0]  frame_type,
    input logic        last
);
    import dsd_pkg::*;

    `DSD_ASSERT_NOW(a_kind_range, clk, rst_n, res_valid,
        kind == KIND_PAYLOAD || kind == KIND_AUDIO || kind == KIND_BAD ||
        kind == KIND_LONG || kind == KIND_OTHER)
    `DSD_ASSERT_NOW(a_payload_audio, clk, rst_n, res_valid && kind == KIND_PAYLOAD,
        frame_type == TYPE_AUDIO)
    `DSD_ASSERT_NOW(a_last_kind, clk, rst_n, res_valid && last,
        kind == KIND_PAYLOAD || kind == KIND_AUDIO)
    `DSD_ASSERT_NOW(a_status_zero_byte, clk, rst_n, res_valid && kind != KIND_PAYLOAD,
        payload_byte == 8'd0)
    `DSD_ASSERT_NEXT(a_stall_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && kind == $past(kind) && payload_byte == $past(payload_byte))
endmodule

bind datagram_stream_deframer_core dsd_checker u_dsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .kind         (result.kind),
    .payload_byte (result.payload_byte),
    .frame_type   (result.frame_type),
    .last         (result.last)
);
